/* hdl/urpa_pkg.sv */
// Shared types and constants for the ultrasonic ranger with proximity alarm.
package urpa_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_PERIOD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_PERIOD   = 3'd6;

    localparam logic [9:0]  RST_TRIGGER_LEN  = 10'd10;
    localparam logic [15:0] RST_RISE_TIMEOUT = 16'd10000;
    localparam logic [15:0] RST_FALL_TIMEOUT = 16'd50000;
    localparam logic [10:0] RST_NEAR_LIMIT   = 11'd10;
    localparam logic [10:0] RST_FAR_LIMIT    = 11'd30;
    localparam logic [19:0] RST_NEAR_PERIOD  = 20'd100000;
    localparam logic [19:0] RST_FAR_PERIOD   = 20'd500000;

    localparam logic [1:0] RPH_TRIG = 2'd0;
    localparam logic [1:0] RPH_RISE = 2'd1;
    localparam logic [1:0] RPH_FALL = 2'd2;

    localparam logic [1:0] APH_IDLE = 2'd0;
    localparam logic [1:0] APH_ON   = 2'd1;
    localparam logic [1:0] APH_OFF  = 2'd2;

    // floor(t*17/1000) = (t * DIST_MULT) >> DIST_SHIFT, exact for 16-bit t
    localparam int          DIST_SHIFT = 26;
    localparam logic [20:0] DIST_MULT  = 21'd1140851;

    typedef struct packed {
        logic echo_level;
        logic alarm_enable;
        logic horn_active;
    } t_in_item;

    typedef struct packed {
        logic        trigger_out;
        logic        led_out;
        logic        buzzer_on;
        logic [10:0] distance_cm;
        logic        distance_new;
    } t_out_item;

    typedef struct packed {
        logic [9:0]  trigger_len_us;
        logic [15:0] rise_timeout_us;
        logic [15:0] fall_timeout_us;
        logic [10:0] near_limit_cm;
        logic [10:0] far_limit_cm;
        logic [19:0] near_period_us;
        logic [19:0] far_period_us;
    } t_cfg;

    typedef struct packed {
        logic        trig;
        logic        fresh;
        logic [10:0] distance;
    } t_rng_res;

    typedef struct packed {
        logic led;
        logic buzzer;
    } t_alm_res;

endpackage

/* hdl/ultrasonic_ranger_proximity_alarm.sv */
// Ultrasonic ranger with proximity alarm. Each input item is one microsecond
// tick; every item yields exactly one result item. The ranger and alarm state
// registers plus the next-state logic (including one 16x21 multiply for the
// distance scale) feed the output register directly, so one item is taken per
// clock as long as the output register is empty or being drained in the same
// cycle. The result becomes valid in the cycle after acceptance. Configuration
// registers are written through a plain write port; the user must write them
// only while no item is in flight, as the block does not enforce this.
module ultrasonic_ranger_proximity_alarm
    import urpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_out_item r_out;
    logic      r_out_valid;
    logic      w_adv;
    t_rng_res  w_rng;
    t_alm_res  w_alm;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_adv      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_len_us  <= RST_TRIGGER_LEN;
            r_cfg.rise_timeout_us <= RST_RISE_TIMEOUT;
            r_cfg.fall_timeout_us <= RST_FALL_TIMEOUT;
            r_cfg.near_limit_cm   <= RST_NEAR_LIMIT;
            r_cfg.far_limit_cm    <= RST_FAR_LIMIT;
            r_cfg.near_period_us  <= RST_NEAR_PERIOD;
            r_cfg.far_period_us   <= RST_FAR_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRIGGER_LEN:  r_cfg.trigger_len_us  <= i_cfg_data[9:0];
                CFG_RISE_TIMEOUT: r_cfg.rise_timeout_us <= i_cfg_data[15:0];
                CFG_FALL_TIMEOUT: r_cfg.fall_timeout_us <= i_cfg_data[15:0];
                CFG_NEAR_LIMIT:   r_cfg.near_limit_cm   <= i_cfg_data[10:0];
                CFG_FAR_LIMIT:    r_cfg.far_limit_cm    <= i_cfg_data[10:0];
                CFG_NEAR_PERIOD:  r_cfg.near_period_us  <= i_cfg_data;
                CFG_FAR_PERIOD:   r_cfg.far_period_us   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    urpa_ranger u_ranger (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_echo  (i_in_item.echo_level),
        .i_cfg   (r_cfg),
        .o_res   (w_rng)
    );

    urpa_alarm u_alarm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_enable   (i_in_item.alarm_enable),
        .i_horn     (i_in_item.horn_active),
        .i_distance (w_rng.distance),
        .i_cfg      (r_cfg),
        .o_res      (w_alm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.trigger_out  <= w_rng.trig;
            r_out.led_out      <= w_alm.led;
            r_out.buzzer_on    <= w_alm.buzzer;
            r_out.distance_cm  <= w_rng.distance;
            r_out.distance_new <= w_rng.fresh;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* hdl/urpa_ranger.sv */
// Ranger sequencer: trigger pulse, echo rise wait, echo width count, distance.
module urpa_ranger
    import urpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  logic     i_echo,
    input  t_cfg     i_cfg,
    output t_rng_res o_res
);

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    logic [10:0] r_dist, n_dist;
    logic [15:0] w_elapsed;
    logic [36:0] w_prod;
    logic        w_trig, w_fresh;

    assign w_elapsed = (r_timer == 16'hFFFF) ? r_timer : r_timer + 16'd1;
    assign w_prod    = 37'(w_elapsed) * 37'(DIST_MULT);

    always_comb begin
        n_phase = r_phase;
        n_timer = w_elapsed;
        n_dist  = r_dist;
        w_trig  = 1'b0;
        w_fresh = 1'b0;
        unique case (r_phase)
            RPH_RISE: begin
                if (i_echo || w_elapsed >= i_cfg.rise_timeout_us) begin
                    n_phase = RPH_FALL;
                    n_timer = '0;
                end
            end
            RPH_FALL: begin
                if (!i_echo || w_elapsed >= i_cfg.fall_timeout_us) begin
                    n_dist  = w_prod[DIST_SHIFT +: 11];
                    w_fresh = 1'b1;
                    n_phase = RPH_TRIG;
                    n_timer = '0;
                end
            end
            default: begin
                w_trig  = 1'b1;
                n_phase = RPH_TRIG;
                if (w_elapsed >= 16'(i_cfg.trigger_len_us)) begin
                    n_phase = RPH_RISE;
                    n_timer = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= RPH_TRIG;
            r_timer <= '0;
            r_dist  <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_dist  <= n_dist;
        end
    end

    assign o_res.trig     = w_trig;
    assign o_res.fresh    = w_fresh;
    assign o_res.distance = n_dist;

endmodule

/* hdl/urpa_alarm.sv */
// Proximity alarm: distance band select and LED/buzzer on/off cycle.
module urpa_alarm
    import urpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_enable,
    input  logic        i_horn,
    input  logic [10:0] i_distance,
    input  t_cfg        i_cfg,
    output t_alm_res    o_res
);

    logic [1:0]  r_phase, n_phase;
    logic [19:0] r_timer, n_timer;
    logic [19:0] r_off, n_off;
    logic        r_led, n_led;
    logic        r_buzz, n_buzz;
    logic [19:0] w_dec;

    assign w_dec = (r_timer == '0) ? '0 : r_timer - 20'd1;

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_off   = r_off;
        n_led   = r_led;
        n_buzz  = r_buzz;
        if (r_phase != APH_IDLE) begin
            n_timer = w_dec;
            if (w_dec == '0) begin
                if (r_phase == APH_ON) begin
                    n_buzz  = 1'b0;
                    n_led   = ~r_led;
                    n_timer = r_off;
                    n_phase = APH_OFF;
                end else begin
                    n_phase = APH_IDLE;
                end
            end
        end else if (i_enable && !i_horn) begin
            priority if (i_distance > i_cfg.near_limit_cm &&
                         i_distance <= i_cfg.far_limit_cm) begin
                n_buzz  = 1'b1;
                n_led   = ~r_led;
                n_timer = i_cfg.far_period_us;
                n_off   = i_cfg.far_period_us;
                n_phase = APH_ON;
            end else if (i_distance != '0 && i_distance <= i_cfg.near_limit_cm) begin
                n_buzz  = 1'b1;
                n_led   = ~r_led;
                n_timer = i_cfg.near_period_us;
                n_off   = i_cfg.near_period_us;
                n_phase = APH_ON;
            end else begin
                n_led  = 1'b0;
                n_buzz = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= APH_IDLE;
            r_timer <= '0;
            r_off   <= '0;
            r_led   <= 1'b0;
            r_buzz  <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_off   <= n_off;
            r_led   <= n_led;
            r_buzz  <= n_buzz;
        end
    end

    assign o_res.led    = n_led;
    assign o_res.buzzer = n_buzz;

endmodule

/* hdl/urpa_checker.sv */
// Port-level checker for the ranger/alarm block, with its bind.
module urpa_checker
    import urpa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_item_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted item produced no result");

    a_fresh_no_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.distance_new) |-> !o_out_item.trigger_out)
        else $error("new distance during trigger pulse");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind ultrasonic_ranger_proximity_alarm urpa_checker u_urpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
